// File: design/dpbf_pkg.sv
`timescale 1ns / 1ps
// Package for the push-both, pop-front deque: sizes, command and status codes,
// and the command bundle from the controller to the datapath. No dependencies.
package dpbf_pkg;

  // Store geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Item field widths.
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // Stream word widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP        = 2'd3;

  // Result status.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // Controller commands to the datapath.
  typedef struct packed {
    logic exec;      // accepted request: update pointers, write or read the store
    logic load_out;  // move the finished result into the output register
  } dpbf_ctrl_t;

endpackage

// File: design/dpbf_ctrl.sv
`timescale 1ns / 1ps
// Controller of the deque: two-state sequencer and output valid flag.
// Depends on dpbf_pkg.
module dpbf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output dpbf_pkg::dpbf_ctrl_t ctrl
);
  import dpbf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  // The output slot can take a new result when empty or being drained.
  assign out_free      = !m_tvalid || m_tready;
  assign s_tready      = (state == ST_IDLE);
  assign ctrl.exec     = s_tvalid && s_tready;
  assign ctrl.load_out = (state == ST_LOAD) && out_free;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (ctrl.exec) state_next = ST_LOAD;
      ST_LOAD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: design/dpbf_datapath.sv
`timescale 1ns / 1ps
// Datapath of the deque: ring store, front and back pointers, fill count and
// the result registers. Depends on dpbf_pkg.
module dpbf_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dpbf_pkg::dpbf_ctrl_t              ctrl,
  input  logic [dpbf_pkg::CMD_W-1:0]        cmd,
  input  logic [dpbf_pkg::VALUE_W-1:0]      push_value,
  output logic [dpbf_pkg::VALUE_W-1:0]      pop_value,
  output logic [dpbf_pkg::STATUS_W-1:0]     status,
  output logic [dpbf_pkg::FILL_W-1:0]       fill_count
);
  import dpbf_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] head_next;
  logic [ADDR_W-1:0] tail_next;
  logic [CNT_W-1:0]  count_next;

  logic [ADDR_W-1:0]   head_inc;
  logic [ADDR_W-1:0]   head_dec;
  logic [ADDR_W-1:0]   tail_inc;
  logic                full;
  logic                empty;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [STATUS_W-1:0] res_status;
  logic                pop_ok;

  logic [STATUS_W-1:0] res_status_q;
  logic                pop_ok_q;
  logic [CNT_W-1:0]    res_count_q;

  // Ring pointer arithmetic with wrap at the store depth.
  assign head_inc = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? ADDR_W'(DEPTH - 1) : head - 1'b1;
  assign tail_inc = (tail == ADDR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  // Command decode and next pointer values.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = tail;
    res_status = STAT_OK;
    pop_ok     = 1'b0;
    unique case (cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          res_status = STAT_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = tail;
          tail_next  = tail_inc;
          count_next = count + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          res_status = STAT_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          res_status = STAT_EMPTY;
        end else begin
          pop_ok     = 1'b1;
          count_next = count - 1'b1;
          // The last word leaves: both ends return to slot zero.
          if (count == CNT_W'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            head_next = head_inc;
          end
        end
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Pointer and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctrl.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Ring store: one write port, one registered read port at the front.
  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      mem[wr_addr] <= push_value[DATA_WIDTH-1:0];
    end
    if (ctrl.exec) begin
      rd_data <= mem[head];
    end
  end

  // Result of the request in flight.
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      res_status_q <= res_status;
      pop_ok_q     <= pop_ok;
      res_count_q  <= count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      pop_value  <= pop_ok_q ? VALUE_W'(rd_data) : '0;
      status     <= res_status_q;
      fill_count <= FILL_W'(res_count_q);
    end
  end

endmodule

// File: design/deque_push_both_pop_front_unit.sv
`timescale 1ns / 1ps
// Deque with push at both ends and pop at the front, over a 16-word ring store.
// Result path: a request's result is first registered in the datapath's result
// registers, then moved into the output register, which waits while it still
// holds a result that has not been taken. A new request is accepted only once
// the result of the last one has moved into the output register.
// Reset (rst, synchronous): queue empty, both ends at slot zero, no result.
// Depends on dpbf_pkg, dpbf_ctrl and dpbf_datapath.
module deque_push_both_pop_front_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: cmd[1:0], push_value[33:2], zero pad[39:34].
  input  logic [dpbf_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // Fields from bit 0: pop_value[31:0], status[33:32], fill_count[38:34], zero pad[39].
  output logic [dpbf_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import dpbf_pkg::*;

  dpbf_ctrl_t          ctrl;
  logic [VALUE_W-1:0]  pop_value;
  logic [STATUS_W-1:0] status;
  logic [FILL_W-1:0]   fill_count;

  // Sequencer.
  dpbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  // Store, pointers and result registers.
  dpbf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cmd        (s_tdata[CMD_W-1:0]),
    .push_value (s_tdata[CMD_W +: VALUE_W]),
    .pop_value  (pop_value),
    .status     (status),
    .fill_count (fill_count)
  );

  // Pack the result word.
  assign m_tdata = {{(OUT_TDATA_W - VALUE_W - STATUS_W - FILL_W){1'b0}},
                    fill_count, status, pop_value};

endmodule
